@@ hdl/job_record_table_with_expiry_defines.svh @@
// Assertion macros for the job record table.
`ifndef JOB_RECORD_TABLE_WITH_EXPIRY_DEFINES_SVH
`define JOB_RECORD_TABLE_WITH_EXPIRY_DEFINES_SVH
`ifndef SYNTHESIS
`define JRT_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define JRT_ASSERT_NXT(label, clk, rst_n, a, c, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`else
`define JRT_ASSERT_IMP(label, clk, rst_n, a, c, msg)
`define JRT_ASSERT_NXT(label, clk, rst_n, a, c, msg)
`endif
`endif

@@ hdl/jrt_pkg.sv @@
// Shared types and constants for the job record table.
`timescale 1ns / 1ps
package jrt_pkg;
	localparam int TABLE_DEPTH = 16;
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int RESULT_CAP = 16;
	localparam logic [31:0] TTL_RESET = 32'd3600000;

	localparam logic [2:0] ACT_BEGIN = 3'd0;
	localparam logic [2:0] ACT_UPDATE = 3'd1;
	localparam logic [2:0] ACT_ATTACH = 3'd2;
	localparam logic [2:0] ACT_FIND = 3'd3;
	localparam logic [2:0] ACT_SNAP = 3'd4;

	typedef struct packed {
		logic [2:0] action;
		logic [63:0] now_ms;
		logic [31:0] job_id;
		logic [2:0] job_state;
		logic [31:0] upstream_id;
		logic [31:0] doc_bytes;
		logic [4:0] max_records;
	} in_item_t;

	typedef struct packed {
		logic [31:0] result_id;
		logic found;
		logic [2:0] rec_state;
		logic [63:0] rec_started_ms;
		logic [63:0] rec_updated_ms;
		logic [31:0] rec_doc_bytes;
		logic [31:0] rec_upstream_id;
		logic rec_has_upstream;
		logic last;
	} out_item_t;

	typedef struct packed {
		logic [31:0] id;
		logic [2:0] st;
		logic [63:0] started;
		logic [63:0] updated;
		logic [31:0] doc;
		logic [31:0] up;
		logic has_up;
	} rec_t;

	// commands from controller to datapath
	typedef enum logic [3:0] {
		CMD_NONE, CMD_LOAD, CMD_RD, CMD_PRUNE, CMD_SHIFT, CMD_APPEND,
		CMD_MATCH, CMD_MODIFY, CMD_EMIT, CMD_SIMPLE
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t op;
		logic [IDX_W-1:0] rd_idx;
		logic [IDX_W-1:0] wr_idx;
		logic [CNT_W-1:0] kept;
		logic ok;
		logic last;
	} cmd_t;

	typedef struct packed {
		logic expired;
		logic id_hit;
		logic up_hit;
		logic [CNT_W-1:0] live;
		in_item_t item;
	} stat_t;
endpackage

@@ hdl/jrt_datapath.sv @@
// Datapath: record memory, item register, compare logic and result register.
`timescale 1ns / 1ps
module jrt_datapath (
	input logic clk,
	input logic arst_n,
	input jrt_pkg::in_item_t in_item,
	input logic [31:0] ttl_ms,
	input jrt_pkg::cmd_t cmd,
	input logic [jrt_pkg::CNT_W-1:0] live_d,
	input logic live_we,
	output jrt_pkg::stat_t stat,
	output jrt_pkg::out_item_t res
);
	import jrt_pkg::*;

	rec_t mem [TABLE_DEPTH];
	rec_t rd_q;
	in_item_t item_q;
	logic [CNT_W-1:0] live_q;
	logic [31:0] last_id_q;
	logic [31:0] next_id;
	logic [63:0] age;

	assign next_id = (last_id_q == 32'hFFFF_FFFF) ? 32'd1 : last_id_q + 32'd1;
	assign age = item_q.now_ms - rd_q.updated;

	// compare the record just read
	always_comb begin
		stat.expired = (item_q.now_ms >= rd_q.updated) && (age >= {32'd0, ttl_ms});
		stat.id_hit = rd_q.id == item_q.job_id;
		stat.up_hit = rd_q.has_up && (rd_q.up == item_q.upstream_id);
		stat.live = live_q;
		stat.item = item_q;
	end

	// hold the counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q <= '0;
			last_id_q <= '0;
		end else begin
			if (live_we) live_q <= live_d;
			if (cmd.op == CMD_APPEND) last_id_q <= next_id;
		end
	end

	// read, write and result registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			CMD_LOAD: item_q <= in_item;
			CMD_RD: rd_q <= mem[cmd.rd_idx];
			CMD_PRUNE, CMD_SHIFT: begin
				mem[cmd.wr_idx] <= rd_q;
				rd_q <= mem[cmd.rd_idx];
			end
			CMD_APPEND: begin
				mem[cmd.wr_idx] <= '{id: next_id, st: item_q.job_state,
					started: item_q.now_ms, updated: item_q.now_ms,
					doc: 32'd0, up: 32'd0, has_up: 1'b0};
				res <= '{result_id: next_id, found: 1'b1, last: 1'b1, default: '0};
			end
			CMD_MODIFY: begin
				if (item_q.action == ACT_UPDATE) begin
					mem[cmd.wr_idx] <= '{id: rd_q.id, st: item_q.job_state,
						started: rd_q.started, updated: item_q.now_ms,
						doc: (item_q.doc_bytes != 32'd0) ? item_q.doc_bytes : rd_q.doc,
						up: rd_q.up, has_up: rd_q.has_up};
				end else begin
					mem[cmd.wr_idx] <= '{id: rd_q.id, st: rd_q.st,
						started: rd_q.started, updated: item_q.now_ms,
						doc: rd_q.doc, up: item_q.upstream_id, has_up: 1'b1};
				end
				res <= '{result_id: item_q.job_id, found: 1'b1, last: 1'b1, default: '0};
			end
			CMD_MATCH:
				res <= '{result_id: rd_q.id, found: 1'b1, last: 1'b1, default: '0};
			CMD_EMIT:
				res <= '{result_id: rd_q.id, found: 1'b1, rec_state: rd_q.st,
					rec_started_ms: rd_q.started, rec_updated_ms: rd_q.updated,
					rec_doc_bytes: rd_q.doc, rec_upstream_id: rd_q.up,
					rec_has_upstream: rd_q.has_up, last: cmd.last};
			CMD_SIMPLE:
				res <= '{found: 1'b0, last: 1'b1, default: '0};
			default: ;
		endcase
	end
endmodule

@@ hdl/jrt_ctrl.sv @@
// Controller: sequences prune, evict, search and snapshot over the table.
`timescale 1ns / 1ps
module jrt_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input logic out_ready,
	input jrt_pkg::stat_t stat,
	output jrt_pkg::cmd_t cmd,
	output logic [jrt_pkg::CNT_W-1:0] live_d,
	output logic live_we
);
	import jrt_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_DISPATCH, S_PRUNE_RD, S_PRUNE, S_SHIFT_RD, S_SHIFT, S_APPEND,
		S_SEARCH_RD, S_SEARCH, S_SNAP_RD, S_EMIT, S_OUT
	} state_t;

	state_t state_q;
	logic [CNT_W-1:0] i_q, kept_q, n_q, e_q;
	logic out_valid_q;
	logic snap_q;
	logic [CNT_W-1:0] lim;
	logic [CNT_W-1:0] last_i;
	logic [CNT_W-1:0] live_nx;

	assign in_ready = (state_q == S_IDLE) && !out_valid_q;
	assign out_valid = out_valid_q;
	assign last_i = i_q - CNT_W'(1);
	assign live_nx = kept_q + CNT_W'(!stat.expired);
	assign lim = (CNT_W'(stat.item.max_records) < live_nx) ?
		CNT_W'(stat.item.max_records) : live_nx;

	// drive datapath commands from state
	always_comb begin
		cmd = '{op: CMD_NONE, default: '0};
		live_d = '0;
		live_we = 1'b0;
		cmd.rd_idx = i_q[IDX_W-1:0];
		cmd.wr_idx = kept_q[IDX_W-1:0];
		case (state_q)
			S_IDLE: if (in_valid && in_ready) cmd.op = CMD_LOAD;
			S_PRUNE_RD, S_SEARCH_RD, S_SNAP_RD: cmd.op = CMD_RD;
			S_SHIFT_RD: begin
				// load the record that moves into slot 0
				cmd.op = CMD_RD;
				cmd.rd_idx = IDX_W'(1);
			end
			S_PRUNE: begin
				if (stat.live != '0) begin
					if (!stat.expired && kept_q != last_i) cmd.op = CMD_PRUNE;
					else cmd.op = CMD_RD;
					cmd.wr_idx = kept_q[IDX_W-1:0];
					if (i_q == stat.live) begin
						live_we = 1'b1;
						live_d = live_nx;
					end
				end
			end
			S_SHIFT: begin
				cmd.op = CMD_SHIFT;
				cmd.wr_idx = last_i[IDX_W-1:0] - IDX_W'(1);
				if (i_q == CNT_W'(TABLE_DEPTH)) begin
					live_we = 1'b1;
					live_d = CNT_W'(TABLE_DEPTH - 1);
				end
			end
			S_APPEND: begin
				cmd.op = CMD_APPEND;
				cmd.wr_idx = stat.live[IDX_W-1:0];
				live_we = 1'b1;
				live_d = stat.live + CNT_W'(1);
			end
			S_SEARCH: begin
				if (stat.live != '0 &&
						(stat.item.action == ACT_FIND ? stat.up_hit : stat.id_hit)) begin
					cmd.op = (stat.item.action == ACT_FIND) ? CMD_MATCH : CMD_MODIFY;
					cmd.wr_idx = (stat.item.action == ACT_FIND) ? last_i[IDX_W-1:0]
						: last_i[IDX_W-1:0];
				end else if (i_q == e_q) begin
					cmd.op = CMD_SIMPLE;
				end
			end
			S_EMIT: begin
				// empty snapshot gives one item with found clear and last set, all other fields zero
				if (n_q == '0) cmd.op = CMD_SIMPLE;
				else begin
					cmd.op = CMD_EMIT;
					cmd.last = (n_q == CNT_W'(1));
				end
			end
			default: ;
		endcase
	end

	// hold state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			i_q <= '0;
			kept_q <= '0;
			n_q <= '0;
			e_q <= '0;
			out_valid_q <= 1'b0;
			snap_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: if (in_valid && in_ready) state_q <= S_DISPATCH;
				S_DISPATCH: begin
					i_q <= '0;
					kept_q <= '0;
					snap_q <= stat.item.action == ACT_SNAP;
					case (stat.item.action)
						ACT_BEGIN, ACT_SNAP: begin
							if (stat.live == '0) state_q <= S_PRUNE;
							else state_q <= S_PRUNE_RD;
						end
						ACT_UPDATE, ACT_ATTACH, ACT_FIND: begin
							if (stat.live == '0) begin
								state_q <= S_SEARCH;
								e_q <= '0;
							end else begin
								state_q <= S_SEARCH_RD;
								e_q <= stat.live;
								i_q <= (stat.item.action == ACT_FIND) ? stat.live - CNT_W'(1)
									: '0;
							end
						end
						default: state_q <= S_IDLE;
					endcase
				end
				S_PRUNE_RD: begin
					state_q <= S_PRUNE;
					i_q <= CNT_W'(1);
				end
				S_PRUNE: begin
					if (stat.live == '0) begin
						// empty table: nothing to prune
						kept_q <= '0;
						n_q <= '0;
						state_q <= snap_q ? S_SNAP_RD : S_APPEND;
					end else begin
						if (!stat.expired) kept_q <= kept_q + CNT_W'(1);
						if (i_q == stat.live) begin
							if (snap_q) begin
								// start the snapshot at the newest kept record
								n_q <= lim;
								i_q <= live_nx - CNT_W'(1);
								state_q <= S_SNAP_RD;
							end else if (live_nx == CNT_W'(TABLE_DEPTH)) begin
								state_q <= S_SHIFT_RD;
							end else state_q <= S_APPEND;
						end else i_q <= i_q + CNT_W'(1);
					end
				end
				S_SHIFT_RD: begin
					i_q <= CNT_W'(2);
					state_q <= S_SHIFT;
				end
				S_SHIFT: begin
					if (i_q == CNT_W'(TABLE_DEPTH)) state_q <= S_APPEND;
					else i_q <= i_q + CNT_W'(1);
				end
				S_APPEND: state_q <= S_OUT;
				S_SEARCH_RD: begin
					state_q <= S_SEARCH;
					i_q <= (stat.item.action == ACT_FIND) ? i_q : i_q + CNT_W'(1);
					e_q <= (stat.item.action == ACT_FIND) ? '0 : e_q;
				end
				S_SEARCH: begin
					if (cmd.op != CMD_NONE) state_q <= S_OUT;
					else if (stat.item.action == ACT_FIND) begin
						i_q <= i_q - CNT_W'(1);
						state_q <= S_SEARCH_RD;
					end else state_q <= S_SEARCH_RD;
				end
				S_SNAP_RD: state_q <= S_EMIT;
				S_EMIT: begin
					out_valid_q <= 1'b1;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_valid_q) out_valid_q <= 1'b1;
					if (out_valid_q && out_ready) begin
						out_valid_q <= 1'b0;
						if (snap_q && n_q > CNT_W'(1)) begin
							n_q <= n_q - CNT_W'(1);
							i_q <= i_q - CNT_W'(1);
							state_q <= S_SNAP_RD;
						end else state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

@@ hdl/job_record_table_with_expiry.sv @@
// Top level of the job record table with expiry.
// Begin and snapshot first prune expired records; a begin that finds the table full
// then evicts the oldest record before it appends. Update, attach and find compare
// the records one at a time; snapshot records are given out one result at a time.
// One item is in work at a time; the next can be taken in the cycle after its last result is taken.
// Reset (arst_n low) empties the table, clears the id counter and loads the TTL.
`timescale 1ns / 1ps
`include "job_record_table_with_expiry_defines.svh"
module job_record_table_with_expiry (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input jrt_pkg::in_item_t in_data,
	output logic out_valid,
	input logic out_ready,
	output jrt_pkg::out_item_t out_data,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [31:0] cfg_data
);
	import jrt_pkg::*;

	logic [31:0] ttl_q;
	cmd_t cmd;
	stat_t stat;
	logic [CNT_W-1:0] live_d;
	logic live_we;

	assign cfg_ready = 1'b1;

	// hold the TTL register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ttl_q <= TTL_RESET;
		else if (cfg_valid) ttl_q <= cfg_data;
	end

	jrt_ctrl u_ctrl (.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready,
		.stat, .cmd, .live_d, .live_we);

	jrt_datapath u_dp (.clk, .arst_n, .in_item(in_data), .ttl_ms(ttl_q), .cmd,
		.live_d, .live_we, .stat, .res(out_data));

	`JRT_ASSERT_NXT(a_out_holds, clk, arst_n, out_valid && !out_ready, out_valid, "result dropped")
	`JRT_ASSERT_IMP(a_no_accept_busy, clk, arst_n, out_valid, !in_ready, "accept while busy")
	`JRT_ASSERT_IMP(a_live_range, clk, arst_n, live_we, live_d <= CNT_W'(TABLE_DEPTH), "live over depth")
endmodule
